/* rtl/rga_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_pkg
// Shared widths, codes and control types of the rational gcd reduce block.
// ----------------------------------------------------------------------------
package rga_pkg;

	// port width of every numerator and denominator field
	localparam int PORT_BITS = 64;
	// arithmetic word width, 8 to 64
	localparam int WORD_BITS = 64;
	// operand magnitudes are split in two halves for the partial products
	localparam int HALF_BITS = (WORD_BITS + 1) / 2;
	localparam int MAG_BITS  = 2 * HALF_BITS;
	localparam int PROD_BITS = 2 * MAG_BITS;
	localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
	localparam int SH_BITS   = $clog2(WORD_BITS);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// operand pairs fed to the multiplier
	typedef enum logic [2:0] {
		PAIR_AN_BN,
		PAIR_AN_BD,
		PAIR_BN_AD,
		PAIR_AD_BN,
		PAIR_AD_BD
	} pair_t;

	// where a truncated product lands
	typedef enum logic [1:0] {
		DEST_N,
		DEST_T,
		DEST_D
	} dest_t;

	typedef enum logic [1:0] {
		RES_NORMAL,
		RES_ZERO,
		RES_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M1,
		S_M1W,
		S_M2,
		S_M2W,
		S_ADD,
		S_M3,
		S_M3W,
		S_CHECK,
		S_GCD,
		S_DIVNW,
		S_DIVDW,
		S_OUT
	} state_t;

	typedef struct packed {
		logic  load;
		logic  mul_start;
		pair_t pair;
		logic  mul_store;
		dest_t dest;
		logic  add_sub;
		logic  gcd_load;
		logic  gcd_step;
		logic  div_start;
		logic  div_sel_den;
		logic  div_store_n;
		logic  div_store_d;
		logic  out_load;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic mul_busy;
		logic d_zero;
		logic n_zero;
		logic gcd_done;
		logic div_busy;
		logic out_free;
	} stat_t;

	// magnitude of a two's complement word, the most negative value stays as 2^(w-1)
	function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] x);
		return x[WORD_BITS-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

/* rtl/rga_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_if
// Valid/ready channels for operand items and reduced results.
// ----------------------------------------------------------------------------
interface rga_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic signed [63:0] a_num;
	logic signed [63:0] a_den;
	logic signed [63:0] b_num;
	logic signed [63:0] b_den;

	modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rga_out_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] res_num;
	logic signed [63:0] res_den;
	logic [1:0]  status;

	modport source (output valid, res_num, res_den, status, input ready);
	modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

/* rtl/rga_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rga_div
	import rga_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 busy,
	output logic [WORD_BITS-1:0] quotient
);

	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0] quo_q;
	logic [WORD_BITS-1:0] dsr_q;
	logic [WORD_BITS:0]   shifted;
	logic [WORD_BITS:0]   diff;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[WORD_BITS-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(WORD_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[WORD_BITS]) begin
				rem_q <= diff[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

/* rtl/rga_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_datapath
// Operand store, partial product multiplier, binary gcd, divider and result.
// ----------------------------------------------------------------------------
module rga_datapath
	import rga_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [1:0]         op,
	input  logic signed [63:0] a_num,
	input  logic signed [63:0] a_den,
	input  logic signed [63:0] b_num,
	input  logic signed [63:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] res_num,
	output logic signed [63:0] res_den,
	output logic [1:0]         status
);

	localparam logic [PROD_BITS-1:0] LIM_P = PROD_BITS'(1) << (WORD_BITS - 1);

	op_t                  op_q;
	logic [WORD_BITS-1:0] an_q, ad_q, bn_q, bd_q;
	logic [WORD_BITS-1:0] n_q, t_q, d_q;
	logic                 ovf_q;

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(op);
			an_q <= a_num[WORD_BITS-1:0];
			ad_q <= a_den[WORD_BITS-1:0];
			bn_q <= b_num[WORD_BITS-1:0];
			bd_q <= b_den[WORD_BITS-1:0];
		end
	end

	// multiplier operand select
	logic [WORD_BITS-1:0] sel_x, sel_y;
	always_comb begin
		case (cmd.pair)
			PAIR_AN_BN: begin sel_x = an_q; sel_y = bn_q; end
			PAIR_AN_BD: begin sel_x = an_q; sel_y = bd_q; end
			PAIR_BN_AD: begin sel_x = bn_q; sel_y = ad_q; end
			PAIR_AD_BN: begin sel_x = ad_q; sel_y = bn_q; end
			PAIR_AD_BD: begin sel_x = ad_q; sel_y = bd_q; end
			default:    begin sel_x = ad_q; sel_y = bd_q; end
		endcase
	end

	// four half-width partial products, one per cycle
	logic [MAG_BITS-1:0]  mx_q, my_q;
	logic                 mneg_q;
	logic [1:0]           mcnt_q;
	logic                 mbusy_q;
	logic [PROD_BITS-1:0] acc_q;
	logic [HALF_BITS-1:0] xp, yp;
	logic [MAG_BITS-1:0]  pp;
	logic [PROD_BITS-1:0] pp_sh;

	assign xp = mcnt_q[1] ? mx_q[MAG_BITS-1:HALF_BITS] : mx_q[HALF_BITS-1:0];
	assign yp = mcnt_q[0] ? my_q[MAG_BITS-1:HALF_BITS] : my_q[HALF_BITS-1:0];
	assign pp = MAG_BITS'(xp) * MAG_BITS'(yp);

	always_comb begin
		case (mcnt_q)
			2'd0:    pp_sh = PROD_BITS'(pp);
			2'd3:    pp_sh = PROD_BITS'(pp) << MAG_BITS;
			default: pp_sh = PROD_BITS'(pp) << HALF_BITS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mbusy_q <= 1'b1;
			mcnt_q  <= '0;
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q + 1'b1;
			if (mcnt_q == 2'd3) begin
				mbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mx_q   <= MAG_BITS'(mag_of(sel_x));
			my_q   <= MAG_BITS'(mag_of(sel_y));
			mneg_q <= sel_x[WORD_BITS-1] ^ sel_y[WORD_BITS-1];
			acc_q  <= '0;
		end else if (mbusy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	// signed truncation of the product and its range check
	logic [PROD_BITS-1:0] prod_s;
	logic                 prod_fits;
	assign prod_s    = mneg_q ? (~acc_q + 1'b1) : acc_q;
	assign prod_fits = ((acc_q >> (WORD_BITS - 1)) == '0) || (mneg_q && acc_q == LIM_P);

	// exact sum or difference of the two cross products
	logic [WORD_BITS+1:0] sum;
	logic                 sum_fits;
	always_comb begin
		if (op_q == OP_SUB) begin
			sum = (WORD_BITS+2)'(signed'(n_q)) - (WORD_BITS+2)'(signed'(t_q));
		end else begin
			sum = (WORD_BITS+2)'(signed'(n_q)) + (WORD_BITS+2)'(signed'(t_q));
		end
	end
	assign sum_fits = (sum[WORD_BITS+1] == sum[WORD_BITS])
		&& (sum[WORD_BITS] == sum[WORD_BITS-1]);

	// raw pair registers and overflow flag
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ovf_q <= 1'b0;
		end else if (cmd.mul_store) begin
			ovf_q <= ovf_q | !prod_fits;
			case (cmd.dest)
				DEST_N:  n_q <= prod_s[WORD_BITS-1:0];
				DEST_T:  t_q <= prod_s[WORD_BITS-1:0];
				DEST_D:  d_q <= prod_s[WORD_BITS-1:0];
				default: d_q <= prod_s[WORD_BITS-1:0];
			endcase
		end else if (cmd.add_sub) begin
			ovf_q <= ovf_q | !sum_fits;
			n_q   <= sum[WORD_BITS-1:0];
		end
	end

	// binary gcd of the two magnitudes
	logic [WORD_BITS-1:0] u_q, v_q, nmag_q, dmag_q;
	logic [SH_BITS-1:0]   k_q;
	logic                 sdiff_q;
	logic                 gcd_done;
	logic [WORD_BITS-1:0] gcd_w;

	assign gcd_done = (u_q == '0) || (v_q == '0);
	assign gcd_w    = (u_q | v_q) << k_q;

	always_ff @(posedge clk) begin
		if (cmd.gcd_load) begin
			u_q     <= mag_of(n_q);
			v_q     <= mag_of(d_q);
			nmag_q  <= mag_of(n_q);
			dmag_q  <= mag_of(d_q);
			sdiff_q <= n_q[WORD_BITS-1] ^ d_q[WORD_BITS-1];
			k_q     <= '0;
		end else if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	// shared divider reduces both magnitudes by the gcd
	logic                 div_busy;
	logic [WORD_BITS-1:0] div_quo;
	logic [WORD_BITS-1:0] nq_q, dq_q;

	rga_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_sel_den ? dmag_q : nmag_q),
		.divisor  (gcd_w),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_store_n) begin
			nq_q <= div_quo;
		end
		if (cmd.div_store_d) begin
			dq_q <= div_quo;
		end
	end

	// result register
	logic                 out_valid_q;
	logic signed [63:0]   res_num_q, res_den_q;
	logic [1:0]           status_q;
	logic [WORD_BITS-1:0] den_s;
	logic                 fin_ovf;

	assign den_s   = sdiff_q ? (~dq_q + 1'b1) : dq_q;
	assign fin_ovf = ovf_q | nq_q[WORD_BITS-1] | (dq_q[WORD_BITS-1] & !sdiff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.kind)
				RES_ERROR: begin
					res_num_q <= '0;
					res_den_q <= '0;
					status_q  <= ST_ZERO_DEN;
				end
				RES_ZERO: begin
					res_num_q <= '0;
					res_den_q <= 64'sd1;
					status_q  <= ovf_q ? ST_OVERFLOW : ST_OK;
				end
				default: begin
					res_num_q <= PORT_BITS'(signed'(nq_q));
					res_den_q <= PORT_BITS'(signed'(den_s));
					status_q  <= fin_ovf ? ST_OVERFLOW : ST_OK;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign status    = status_q;

	// status to the controller
	assign stat.op       = op_q;
	assign stat.mul_busy = mbusy_q;
	assign stat.d_zero   = d_q == '0;
	assign stat.n_zero   = n_q == '0;
	assign stat.gcd_done = gcd_done;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || out_ready;

	// checks
	a_mul_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !mbusy_q)
		else $error("multiplier restarted while busy");

	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_ZERO_DEN) |-> (res_num_q == '0 && res_den_q == '0))
		else $error("zero denominator result carries a value");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_ZERO_DEN) |-> (res_den_q != '0))
		else $error("reduced denominator is zero");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transaction");

endmodule

/* rtl/rga_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_ctrl
// Sequencer: products, sum, zero checks, gcd, reduction and result load.
// ----------------------------------------------------------------------------
module rga_ctrl
	import rga_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RES_NORMAL;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.pair = PAIR_AD_BD;
		cmd.dest = DEST_N;
		cmd.kind = kind_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_M1;
				end
			end
			S_M1: begin
				cmd.mul_start = 1'b1;
				cmd.pair      = (stat.op == OP_MUL) ? PAIR_AN_BN : PAIR_AN_BD;
				state_d       = S_M1W;
			end
			S_M1W: begin
				if (!stat.mul_busy) begin
					cmd.mul_store = 1'b1;
					cmd.dest      = DEST_N;
					state_d = (stat.op == OP_ADD || stat.op == OP_SUB) ? S_M2 : S_M3;
				end
			end
			S_M2: begin
				cmd.mul_start = 1'b1;
				cmd.pair      = PAIR_BN_AD;
				state_d       = S_M2W;
			end
			S_M2W: begin
				if (!stat.mul_busy) begin
					cmd.mul_store = 1'b1;
					cmd.dest      = DEST_T;
					state_d       = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add_sub = 1'b1;
				state_d     = S_M3;
			end
			S_M3: begin
				cmd.mul_start = 1'b1;
				cmd.pair      = (stat.op == OP_DIV) ? PAIR_AD_BN : PAIR_AD_BD;
				state_d       = S_M3W;
			end
			S_M3W: begin
				if (!stat.mul_busy) begin
					cmd.mul_store = 1'b1;
					cmd.dest      = DEST_D;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.d_zero) begin
					kind_d  = RES_ERROR;
					state_d = S_OUT;
				end else if (stat.n_zero) begin
					kind_d  = RES_ZERO;
					state_d = S_OUT;
				end else begin
					kind_d       = RES_NORMAL;
					cmd.gcd_load = 1'b1;
					state_d      = S_GCD;
				end
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVNW;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIVNW: begin
				if (!stat.div_busy) begin
					cmd.div_store_n = 1'b1;
					cmd.div_start   = 1'b1;
					cmd.div_sel_den = 1'b1;
					state_d         = S_DIVDW;
				end
			end
			S_DIVDW: begin
				if (!stat.div_busy) begin
					cmd.div_store_d = 1'b1;
					state_d         = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/rational_arith_gcd_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_gcd_reduce
// Rational add, subtract, multiply and divide with gcd reduction.
// ----------------------------------------------------------------------------
// One item is worked at a time. The two or three cross products (three for
// add and subtract, two for multiply and divide) each run on a half-width
// multiplier as four partial products, the gcd runs as a binary gcd at one
// shift or subtract per cycle, and the shared restoring divider then divides
// numerator and denominator by the gcd at one bit per cycle. A zero numerator
// or zero denominator skips the gcd loop and the divider. A finished
// result sits in the output register, so the next transaction is taken while
// it waits to be read.
module rational_arith_gcd_reduce
	import rga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rga_in_if.sink     in_ch,
	rga_out_if.source  out_ch
);

	cmd_t  cmd;
	stat_t stat;

	rga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rga_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op        (in_ch.op),
		.a_num     (in_ch.a_num),
		.a_den     (in_ch.a_den),
		.b_num     (in_ch.b_num),
		.b_den     (in_ch.b_den),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.res_num   (out_ch.res_num),
		.res_den   (out_ch.res_den),
		.status    (out_ch.status)
	);

endmodule
